// ===== design/dq_pkg.sv =====
// Shared types and codes for the double-ended queue core.
// Used by dq_ctrl and double_ended_queue_core; no dependencies.
package dq_pkg;

   localparam int unsigned OCC_BITS = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      status_type            status;
      logic [OCC_BITS-1:0]   occupancy;
   } ctrl_type;

endpackage

// ===== design/dq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dq_ctrl.sv =====
// Head and count bookkeeping for the circular store: decodes a request,
// picks the RAM slot, and gives status and occupancy. Depends on dq_pkg.
module dq_ctrl #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [1:0]               op,
   output dq_pkg::ctrl_type         ctrl,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [$clog2(DEPTH)-1:0] rd_addr
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = CW + 1;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic          full, empty;
   logic [SW-1:0] back_sum, last_sum;
   logic [AW-1:0] back_slot, last_slot, head_dec, head_inc;
   dq_pkg::op_type op_dec;

   assign op_dec = dq_pkg::op_type'(op);
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   // wrap sums that stay below twice the depth
   assign back_sum  = SW'(head_ff) + SW'(count_ff);
   assign last_sum  = back_sum - SW'(1);
   assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
   assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   always_comb begin
      ctrl.wr_en  = 1'b0;
      ctrl.rd_en  = 1'b0;
      ctrl.status = dq_pkg::ST_DONE;
      head_in     = head_ff;
      count_in    = count_ff;
      wr_addr     = back_slot;
      rd_addr     = last_slot;
      unique case (op_dec)
         dq_pkg::OP_PUSH_FRONT: begin
            wr_addr = head_dec;
            if (full) begin
               ctrl.status = dq_pkg::ST_OVERFLOW;
            end else begin
               ctrl.wr_en = 1'b1;
               head_in    = head_dec;
               count_in   = count_ff + CW'(1);
            end
         end
         dq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               ctrl.status = dq_pkg::ST_OVERFLOW;
            end else begin
               ctrl.wr_en = 1'b1;
               count_in   = count_ff + CW'(1);
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            rd_addr = head_ff;
            if (empty) begin
               ctrl.status = dq_pkg::ST_EMPTY;
            end else begin
               ctrl.rd_en = 1'b1;
               head_in    = head_inc;
               count_in   = count_ff - CW'(1);
            end
         end
         dq_pkg::OP_POP_BACK: begin
            if (empty) begin
               ctrl.status = dq_pkg::ST_EMPTY;
            end else begin
               ctrl.rd_en = 1'b1;
               count_in   = count_ff - CW'(1);
            end
         end
         default: begin
            ctrl.status = dq_pkg::ST_DONE;
         end
      endcase
      ctrl.occupancy = dq_pkg::OCC_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/double_ended_queue_core.sv =====
// Double-ended queue core: circular store in one RAM, head and count in flops.
// Push or refused request: result registered in the cycle after acceptance;
// successful pop: RAM read register, then output register. Throughput: 1
// transaction per cycle for pushes and refused requests while results are
// taken; a pop holds off requests until its data is registered. Reset empties
// the queue; store contents stay undefined. Depends on dq_pkg, dq_ctrl, dq_ram.
module double_ended_queue_core #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pop_value,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_occupancy
);

   localparam int unsigned AW = $clog2(DEPTH);

   dq_pkg::state_type state_ff, state_in;
   dq_pkg::ctrl_type  ctrl;

   logic                 req_fire, rsp_fire;
   logic                 load_now, load_read;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_word, rd_word;
   logic [31:0]          rd_value;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   pop_value_ff, pop_value_in;
   dq_pkg::status_type   status_ff, status_in;
   logic [4:0]           occupancy_ff, occupancy_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid_ff && rsp_ready;

   dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .op      (req_op),
      .ctrl    (ctrl),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr)
   );

   generate
      if (WORD_BITS <= 32) begin : g_narrow
         assign wr_word  = req_push_value[WORD_BITS-1:0];
         if (WORD_BITS < 32) begin : g_ext
            assign rd_value = {{(32 - WORD_BITS){rd_word[WORD_BITS-1]}}, rd_word};
         end else begin : g_same
            assign rd_value = rd_word;
         end
      end else begin : g_wide
         assign wr_word  = {{(WORD_BITS - 32){req_push_value[31]}}, req_push_value};
         assign rd_value = rd_word[31:0];
      end
   endgenerate

   dq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (req_fire && ctrl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (req_fire && ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::FSM_IDLE: begin
            if (req_fire && ctrl.rd_en) begin
               state_in = dq_pkg::FSM_READ;
            end
         end
         dq_pkg::FSM_READ: begin
            state_in = dq_pkg::FSM_IDLE;
         end
         default: begin
            state_in = dq_pkg::FSM_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == dq_pkg::FSM_IDLE) && (!rsp_valid_ff || rsp_ready);
      load_now  = req_fire && !ctrl.rd_en;
      load_read = (state_ff == dq_pkg::FSM_READ);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pop_value_in = pop_value_ff;
      status_in    = status_ff;
      occupancy_in = occupancy_ff;
      if (req_fire) begin
         status_in    = ctrl.status;
         occupancy_in = ctrl.occupancy;
         pop_value_in = '0;
      end
      priority if (load_now || load_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (load_read) begin
         pop_value_in = rd_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_value_ff <= pop_value_in;
      status_ff    <= status_in;
      occupancy_ff <= occupancy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = pop_value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occupancy_ff;

   // the output register is free while a pop waits on the RAM
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::FSM_READ) |-> !rsp_valid_ff)
      else $error("result pending while pop read in flight");

   a_read_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::FSM_READ) |=> (rsp_valid_ff && status_ff == dq_pkg::ST_DONE))
      else $error("pop read did not produce a result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != dq_pkg::ST_DONE) |-> (pop_value_ff == '0))
      else $error("refused transaction carries a nonzero value");

endmodule

// ===== sim/dq_tb_pkg.sv =====
// Scoreboard for the double-ended queue core testbench: tracks queue contents
// and compares each response with its predicted value. Depends on dq_pkg.
package dq_tb_pkg;
   import dq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 16;

   typedef struct packed {
      logic [31:0]  pop_value;
      status_type   status;
      logic [4:0]   occupancy;
   } deque_result;

   class deque_scoreboard;
      logic [31:0]  slots [QUEUE_DEPTH];
      logic [3:0]   front_index;
      logic [4:0]   stored_count;
      deque_result  pending_results [$];
      int unsigned  errors;
      int unsigned  push_done, push_refused, pop_done, pop_empty, peak_count;

      function new();
         front_index  = '0;
         stored_count = '0;
         errors       = 0;
         push_done    = 0;
         push_refused = 0;
         pop_done     = 0;
         pop_empty    = 0;
         peak_count   = 0;
      endfunction

      // Advance the queue state for one request and return its result.
      function deque_result apply_request(op_type op, logic [31:0] word);
         deque_result r;
         logic [3:0]  slot;
         r.pop_value = '0;
         r.status    = ST_DONE;
         if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (stored_count == 5'(QUEUE_DEPTH)) begin
               r.status = ST_OVERFLOW;
               push_refused++;
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  front_index = front_index - 4'd1;
                  slot = front_index;
               end else begin
                  slot = 4'(front_index + stored_count);
               end
               slots[slot] = word;
               stored_count++;
               push_done++;
            end
         end else begin
            if (stored_count == '0) begin
               r.status = ST_EMPTY;
               pop_empty++;
            end else begin
               if (op == OP_POP_FRONT) begin
                  slot = front_index;
                  front_index = front_index + 4'd1;
               end else begin
                  slot = 4'(front_index + stored_count - 5'd1);
               end
               r.pop_value = slots[slot];
               stored_count--;
               pop_done++;
            end
         end
         r.occupancy = stored_count;
         if (stored_count > peak_count) peak_count = stored_count;
         return r;
      endfunction

      function void note_request(op_type op, logic [31:0] word);
         pending_results.push_back(apply_request(op, word));
      endfunction

      function void check_response(logic [31:0] pop_value, logic [1:0] status,
                                   logic [4:0] occupancy);
         deque_result want;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: pop_value %0d status %0d",
                   $signed(pop_value), status);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (pop_value !== want.pop_value) begin
            $error("pop_value: expected %0d, got %0d",
                   $signed(want.pop_value), $signed(pop_value));
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction
   endclass

endpackage

// ===== sim/tb_top.sv =====
// Top-level testbench for double_ended_queue_core: directed and random push/pop
// traffic with random stalls on both channels. Depends on dq_pkg and dq_tb_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dq_pkg::*;
   import dq_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op         = OP_PUSH_FRONT;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic signed [31:0] rsp_pop_value;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_occupancy;

   int unsigned        send_idle_pct  = 0;
   int unsigned        recv_idle_pct  = 0;
   int unsigned        cycle_count    = 0;

   deque_scoreboard    tracker = new();

   double_ended_queue_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response(rsp_pop_value, rsp_status, rsp_occupancy);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, tracker.outstanding());
      $display("RESULT: ERROR");
      $finish;
   end

   // Call at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(op_type op, logic [31:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_push_value <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(op, word);
      @(negedge clock);
   endtask

   // Drift between filling and draining so both full and empty are hit often.
   task automatic run_random(int unsigned n_items);
      int unsigned k;
      bit          fill_bias;
      op_type      op;
      logic [31:0] word;
      fill_bias = 1'b1;
      for (k = 0; k < n_items; k++) begin
         if (k % 32 == 0) fill_bias = $urandom_range(1);
         if ($urandom_range(99) < (fill_bias ? 70 : 30))
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else
            op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
         case ($urandom_range(7))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'h0000_0000;
            3:       word = 32'hFFFF_FFFF;
            default: word = $urandom;
         endcase
         send_request(op, word);
      end
   endtask

   initial begin
      int unsigned i;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 64;

      // pops on an empty queue, then extreme words through both ends
      send_request(OP_POP_FRONT,  32'h1234_5678);
      send_request(OP_POP_BACK,   32'hFFFF_FFFF);
      send_request(OP_PUSH_FRONT, 32'h8000_0000);
      send_request(OP_PUSH_BACK,  32'h7FFF_FFFF);
      send_request(OP_POP_FRONT,  32'h0000_0000);
      send_request(OP_POP_BACK,   32'h0000_0000);
      // fill from both ends so the head wraps, then push into a full queue
      for (i = 0; i < QUEUE_DEPTH; i++)
         send_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                      i[0] ? (32'hA5A5_0000 | i) : (32'h5A5A_0000 | i));
      send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send_request(OP_PUSH_BACK,  32'h0000_0000);
      send_request(OP_POP_BACK,   32'h0000_0000);

      run_random(150);
      send_idle_pct = 64;
      recv_idle_pct = 23;
      run_random(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(150);
      req_valid <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d pushes, %0d refused on full, %0d pops, %0d on empty.",
               tracker.push_done, tracker.push_refused, tracker.pop_done,
               tracker.pop_empty);
      $display("Peak occupancy %0d of %0d; %0d mismatches.",
               tracker.peak_count, QUEUE_DEPTH, tracker.errors);
      if (tracker.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== double_ended_queue_core.f =====
design/dq_pkg.sv
design/dq_ram.sv
design/dq_ctrl.sv
design/double_ended_queue_core.sv
sim/dq_tb_pkg.sv
sim/tb_top.sv
